### rtl/mre_pkg.sv
// Shared types and constants of the MIPS relocation engine.
package mre_pkg;

   localparam int SEGMENT_SLOTS_DEF = 16;
   localparam int PENDING_DEPTH_DEF = 16;

   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 72;

   // Item kinds carried in the request tuser
   typedef enum logic [1:0] {
      ACT_SET   = 2'd0,
      ACT_START = 2'd1,
      ACT_APPLY = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   // Relocation type codes
   localparam logic [7:0] RT_NONE  = 8'd0;
   localparam logic [7:0] RT_R32   = 8'd2;
   localparam logic [7:0] RT_R26   = 8'd4;
   localparam logic [7:0] RT_HI16  = 8'd5;
   localparam logic [7:0] RT_LO16  = 8'd6;
   localparam logic [7:0] RT_GPREL = 8'd7;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_UNIMP  = 3'd1,
      ST_GP     = 3'd2,
      ST_BADSEG = 3'd3,
      ST_FULL   = 3'd4
   } status_type;

   // Operations of the shared adder
   typedef enum logic [2:0] {
      ALU_ADD,
      ALU_PASS,
      ALU_R26,
      ALU_LO,
      ALU_HI
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] lo;
   } alu_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ERR,
      S_RD_O,
      S_RD_B,
      S_ADDR,
      S_DATA,
      S_WRD,
      S_WEMIT
   } state_type;

endpackage

### rtl/mre_ram.sv
// Generic single-port-write, registered-read RAM.
module mre_ram #(
   parameter  int WIDTH = 32,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/mre_alu.sv
// Shared 32-bit adder with the patch formatting of each relocation type.
module mre_alu (
   input  mre_pkg::alu_req_type req,
   output logic [31:0]          result
);

   always_comb begin
      logic [31:0] opa;
      logic [31:0] sum;
      logic [15:0] hi_adj;

      // first operand shaped per operation
      case (req.op)
         mre_pkg::ALU_R26: opa = {req.x[25:0], 2'b00};
         mre_pkg::ALU_HI:  opa = {req.x[15:0], req.lo};
         default:          opa = req.x;
      endcase

      sum = opa + req.y;

      // high half with sign correction of the low half and rounding carry
      hi_adj = sum[31:16] + 16'(sum[15]) - 16'(req.lo[15]);

      case (req.op)
         mre_pkg::ALU_ADD:  result = sum;
         mre_pkg::ALU_PASS: result = req.x;
         mre_pkg::ALU_R26:  result = {req.x[31:26], sum[27:2]};
         mre_pkg::ALU_LO:   result = {req.x[31:16], sum[15:0]};
         mre_pkg::ALU_HI:   result = {req.x[31:16], hi_adj};
         default:           result = req.x;
      endcase
   end

endmodule

### rtl/mre_seq.sv
// Sequencer: decodes items, drives table and pending-list RAMs, holds the result register.
module mre_seq #(
   parameter  int SEGMENT_SLOTS = mre_pkg::SEGMENT_SLOTS_DEF,
   parameter  int PENDING_DEPTH = mre_pkg::PENDING_DEPTH_DEF,
   localparam int SW = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1,
   localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1,
   localparam int CW = $clog2(PENDING_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   // request side
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           action,
   input  logic [3:0]           segment_slot,
   input  logic [31:0]          segment_base,
   input  logic [7:0]           reloc_type,
   input  logic [7:0]           offset_segment,
   input  logic [7:0]           base_segment,
   input  logic [31:0]          reloc_offset,
   input  logic [31:0]          target_word,
   // result side
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 write_valid,
   output logic [31:0]          write_address,
   output logic [31:0]          write_data,
   output logic [2:0]           status,
   output logic                 last,
   // segment table RAM
   output logic                 seg_wr_en,
   output logic [SW-1:0]        seg_wr_addr,
   output logic [31:0]          seg_wr_data,
   output logic                 seg_rd_en,
   output logic [SW-1:0]        seg_rd_addr,
   input  logic [31:0]          seg_rd_data,
   // pending HI16 RAM: {address, word}
   output logic                 pend_wr_en,
   output logic [PW-1:0]        pend_wr_addr,
   output logic [63:0]          pend_wr_data,
   output logic                 pend_rd_en,
   output logic [PW-1:0]        pend_rd_addr,
   input  logic [63:0]          pend_rd_data,
   // shared adder
   output mre_pkg::alu_req_type alu_req,
   input  logic [31:0]          alu_result
);

   mre_pkg::state_type  state_ff, state_in;
   logic [7:0]          type_ff, type_in;
   logic [7:0]          oseg_ff, oseg_in;
   logic [7:0]          bseg_ff, bseg_in;
   logic [31:0]         roff_ff, roff_in;
   logic [31:0]         word_ff, word_in;
   logic [31:0]         ofs_ff, ofs_in;
   logic [31:0]         s_ff, s_in;
   logic [31:0]         addr_ff, addr_in;
   mre_pkg::status_type status_ff, status_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [PW-1:0]       idx_ff, idx_in;
   logic                seg_valid_ff [SEGMENT_SLOTS];
   logic                rd_valid_ff, rd_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_wv_ff, out_wv_in;
   logic [31:0]         out_addr_ff, out_addr_in;
   logic [31:0]         out_data_ff, out_data_in;
   mre_pkg::status_type out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   logic                req_fire;
   logic                out_free;
   logic [31:0]         seg_mask;
   logic [7:0]          slot_ext;
   logic                slot_ok;
   logic                segs_ok;
   logic                type_ok;

   assign req_ready = (state_ff == mre_pkg::S_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign seg_mask  = rd_valid_ff ? seg_rd_data : 32'd0;
   assign slot_ext  = {4'd0, segment_slot};
   assign slot_ok   = {1'b0, slot_ext} < 9'(SEGMENT_SLOTS);
   assign segs_ok   = ({1'b0, offset_segment} < 9'(SEGMENT_SLOTS)) &&
                      ({1'b0, base_segment} < 9'(SEGMENT_SLOTS));

   // supported relocation types
   always_comb begin
      case (reloc_type) inside
         mre_pkg::RT_NONE, mre_pkg::RT_R32, mre_pkg::RT_R26,
         mre_pkg::RT_HI16, mre_pkg::RT_LO16: type_ok = 1'b1;
         default:                            type_ok = 1'b0;
      endcase
   end

   // RAM address and data that do not depend on the state decode
   assign seg_wr_addr  = slot_ext[SW-1:0];
   assign seg_wr_data  = segment_base;
   assign seg_rd_addr  = (state_ff == mre_pkg::S_RD_B) ? bseg_ff[SW-1:0] : oseg_ff[SW-1:0];
   assign pend_wr_addr = count_ff[PW-1:0];
   assign pend_wr_data = {addr_ff, word_ff};
   assign pend_rd_addr = idx_ff;

   // next state, RAM strobes, adder operands and result loading
   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      oseg_in       = oseg_ff;
      bseg_in       = bseg_ff;
      roff_in       = roff_ff;
      word_in       = word_ff;
      ofs_in        = ofs_ff;
      s_in          = s_ff;
      addr_in       = addr_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rd_valid_in   = rd_valid_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      out_wv_in     = out_wv_ff;
      out_addr_in   = out_addr_ff;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      seg_wr_en     = 1'b0;
      seg_rd_en     = 1'b0;
      pend_wr_en    = 1'b0;
      pend_rd_en    = 1'b0;
      alu_req.op    = mre_pkg::ALU_PASS;
      alu_req.x     = word_ff;
      alu_req.y     = s_ff;
      alu_req.lo    = word_ff[15:0];

      case (state_ff)
         mre_pkg::S_IDLE: begin
            if (req_fire) begin
               type_in = reloc_type;
               oseg_in = offset_segment;
               bseg_in = base_segment;
               roff_in = reloc_offset;
               word_in = target_word;
               case (mre_pkg::action_type'(action))
                  mre_pkg::ACT_SET: begin
                     seg_wr_en = slot_ok;
                  end
                  mre_pkg::ACT_START: begin
                     count_in = '0;
                  end
                  mre_pkg::ACT_APPLY: begin
                     if (reloc_type == mre_pkg::RT_GPREL) begin
                        status_in = mre_pkg::ST_GP;
                        state_in  = mre_pkg::S_ERR;
                     end else if (!type_ok) begin
                        status_in = mre_pkg::ST_UNIMP;
                        state_in  = mre_pkg::S_ERR;
                     end else if (!segs_ok) begin
                        status_in = mre_pkg::ST_BADSEG;
                        state_in  = mre_pkg::S_ERR;
                     end else begin
                        state_in  = mre_pkg::S_RD_O;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // single status-only result
         mre_pkg::S_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_wv_in     = 1'b0;
               out_addr_in   = 32'd0;
               out_data_in   = 32'd0;
               out_status_in = status_ff;
               out_last_in   = 1'b1;
               state_in      = mre_pkg::S_IDLE;
            end
         end

         // table reads: offset segment, then base segment
         mre_pkg::S_RD_O: begin
            seg_rd_en   = 1'b1;
            rd_valid_in = seg_valid_ff[seg_rd_addr];
            state_in    = mre_pkg::S_RD_B;
         end

         mre_pkg::S_RD_B: begin
            seg_rd_en   = 1'b1;
            rd_valid_in = seg_valid_ff[seg_rd_addr];
            ofs_in      = seg_mask;
            state_in    = mre_pkg::S_ADDR;
         end

         // target address, then branch on the list state
         mre_pkg::S_ADDR: begin
            alu_req.op = mre_pkg::ALU_ADD;
            alu_req.x  = ofs_ff;
            alu_req.y  = roff_ff;
            addr_in    = alu_result;
            s_in       = seg_mask;
            if (type_ff == mre_pkg::RT_HI16 && count_ff == CW'(PENDING_DEPTH)) begin
               status_in = mre_pkg::ST_FULL;
               state_in  = mre_pkg::S_ERR;
            end else if (type_ff == mre_pkg::RT_LO16 && count_ff != '0) begin
               idx_in   = '0;
               state_in = mre_pkg::S_WRD;
            end else begin
               state_in = mre_pkg::S_DATA;
            end
         end

         // patch of the item's own word
         mre_pkg::S_DATA: begin
            case (type_ff)
               mre_pkg::RT_R32:  alu_req.op = mre_pkg::ALU_ADD;
               mre_pkg::RT_R26:  alu_req.op = mre_pkg::ALU_R26;
               mre_pkg::RT_LO16: alu_req.op = mre_pkg::ALU_LO;
               default:          alu_req.op = mre_pkg::ALU_PASS;
            endcase
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_wv_in     = 1'b1;
               out_addr_in   = addr_ff;
               out_data_in   = alu_result;
               out_status_in = mre_pkg::ST_OK;
               out_last_in   = 1'b1;
               if (type_ff == mre_pkg::RT_HI16) begin
                  pend_wr_en = 1'b1;
                  count_in   = count_ff + CW'(1);
               end
               if (type_ff == mre_pkg::RT_LO16) begin
                  count_in = '0;
               end
               state_in = mre_pkg::S_IDLE;
            end
         end

         // pending list walk: read one entry, then patch it
         mre_pkg::S_WRD: begin
            pend_rd_en = 1'b1;
            state_in   = mre_pkg::S_WEMIT;
         end

         mre_pkg::S_WEMIT: begin
            alu_req.op = mre_pkg::ALU_HI;
            alu_req.x  = pend_rd_data[31:0];
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_wv_in     = 1'b1;
               out_addr_in   = pend_rd_data[63:32];
               out_data_in   = alu_result;
               out_status_in = mre_pkg::ST_OK;
               out_last_in   = 1'b0;
               idx_in        = idx_ff + PW'(1);
               if (CW'(idx_ff) + CW'(1) == count_ff) begin
                  state_in = mre_pkg::S_DATA;
               end else begin
                  state_in = mre_pkg::S_WRD;
               end
            end
         end

         default: begin
            state_in = mre_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mre_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SEGMENT_SLOTS; i++) begin
            seg_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (seg_wr_en) begin
            seg_valid_ff[seg_wr_addr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      oseg_ff       <= oseg_in;
      bseg_ff       <= bseg_in;
      roff_ff       <= roff_in;
      word_ff       <= word_in;
      ofs_ff        <= ofs_in;
      s_ff          <= s_in;
      addr_ff       <= addr_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      rd_valid_ff   <= rd_valid_in;
      out_wv_ff     <= out_wv_in;
      out_addr_ff   <= out_addr_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign write_valid   = out_wv_ff;
   assign write_address = out_addr_ff;
   assign write_data    = out_data_ff;
   assign status        = out_status_ff;
   assign last          = out_last_ff;

`ifndef ASSERT_OFF
   // pending list never overfills
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PENDING_DEPTH))
      else $error("pending count above depth");

   // a result that is not the last one of its item is a list-walk write
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_last_ff |-> out_wv_ff && out_status_ff == mre_pkg::ST_OK)
      else $error("non-final result is not a write");

   // an error status never comes with a write and always ends the item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_status_ff != mre_pkg::ST_OK |-> !out_wv_ff && out_last_ff)
      else $error("error result carries a write");

   // a queued HI16 entry bumps the count by one
   assert property (@(posedge clock) disable iff (reset)
      state_ff == mre_pkg::S_DATA && out_free && type_ff == mre_pkg::RT_HI16
      |=> count_ff == $past(count_ff) + CW'(1))
      else $error("HI16 queue count did not advance");
`endif

endmodule

### rtl/mips_relocation_engine_top.sv
// Top level of the MIPS HI16/LO16 relocation engine.
// Type and segment errors go straight to S_ERR; other apply items pass S_RD_O, S_RD_B, S_ADDR
// and then S_DATA, or S_ERR when the HI16 list is full; a LO16 first walks each waiting HI16
// entry through S_WRD and S_WEMIT. Set/start items are taken one per cycle; no new item is
// taken until an apply item's last result is registered.
// Reset (synchronous): empties the pending list, invalidates segment entries so they read as zero, drops held result.
module mips_relocation_engine_top #(
   parameter int SEGMENT_SLOTS = mre_pkg::SEGMENT_SLOTS_DEF,
   parameter int PENDING_DEPTH = mre_pkg::PENDING_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // segment_slot[3:0], segment_base[35:4], reloc_type[43:36], offset_segment[51:44],
   // base_segment[59:52], reloc_offset[91:60], target_word[123:92], zero pad
   input  logic [mre_pkg::REQ_TDATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // write_address[31:0], write_data[63:32], status[66:64], zero pad
   output logic [mre_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // write_valid[0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   localparam int SW = (SEGMENT_SLOTS > 1) ? $clog2(SEGMENT_SLOTS) : 1;
   localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

   logic                 seg_wr_en, seg_rd_en;
   logic [SW-1:0]        seg_wr_addr, seg_rd_addr;
   logic [31:0]          seg_wr_data, seg_rd_data;
   logic                 pend_wr_en, pend_rd_en;
   logic [PW-1:0]        pend_wr_addr, pend_rd_addr;
   logic [63:0]          pend_wr_data, pend_rd_data;
   mre_pkg::alu_req_type alu_req;
   logic [31:0]          alu_result;
   logic [31:0]          write_address, write_data;
   logic [2:0]           status;

   // sequencer and result register
   mre_seq #(
      .SEGMENT_SLOTS (SEGMENT_SLOTS),
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .action         (req_tuser),
      .segment_slot   (req_tdata[3:0]),
      .segment_base   (req_tdata[35:4]),
      .reloc_type     (req_tdata[43:36]),
      .offset_segment (req_tdata[51:44]),
      .base_segment   (req_tdata[59:52]),
      .reloc_offset   (req_tdata[91:60]),
      .target_word    (req_tdata[123:92]),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .write_valid    (rsp_tuser),
      .write_address  (write_address),
      .write_data     (write_data),
      .status         (status),
      .last           (rsp_tlast),
      .seg_wr_en      (seg_wr_en),
      .seg_wr_addr    (seg_wr_addr),
      .seg_wr_data    (seg_wr_data),
      .seg_rd_en      (seg_rd_en),
      .seg_rd_addr    (seg_rd_addr),
      .seg_rd_data    (seg_rd_data),
      .pend_wr_en     (pend_wr_en),
      .pend_wr_addr   (pend_wr_addr),
      .pend_wr_data   (pend_wr_data),
      .pend_rd_en     (pend_rd_en),
      .pend_rd_addr   (pend_rd_addr),
      .pend_rd_data   (pend_rd_data),
      .alu_req        (alu_req),
      .alu_result     (alu_result)
   );

   // segment base table
   mre_ram #(
      .WIDTH (32),
      .DEPTH (SEGMENT_SLOTS)
   ) u_seg_ram (
      .clock   (clock),
      .wr_en   (seg_wr_en),
      .wr_addr (seg_wr_addr),
      .wr_data (seg_wr_data),
      .rd_en   (seg_rd_en),
      .rd_addr (seg_rd_addr),
      .rd_data (seg_rd_data)
   );

   // waiting HI16 entries
   mre_ram #(
      .WIDTH (64),
      .DEPTH (PENDING_DEPTH)
   ) u_pend_ram (
      .clock   (clock),
      .wr_en   (pend_wr_en),
      .wr_addr (pend_wr_addr),
      .wr_data (pend_wr_data),
      .rd_en   (pend_rd_en),
      .rd_addr (pend_rd_addr),
      .rd_data (pend_rd_data)
   );

   // shared adder
   mre_alu u_alu (
      .req    (alu_req),
      .result (alu_result)
   );

   assign rsp_tdata = {5'd0, status, write_data, write_address};

endmodule

### bench/tb_reloc_pkg.sv
// Request and patch types plus the write-patch scoreboard of the relocation engine bench.
`timescale 1ns / 100ps
package tb_reloc_pkg;
   import mre_pkg::*;

   // R16 has no package constant: the block only ever flags it as unsupported
   localparam logic [7:0]  RT_R16      = 8'd1;
   localparam logic [31:0] R26_FIELD   = 32'h03FF_FFFF;
   localparam logic [31:0] HALF_STEP   = 32'h0001_0000;
   localparam int          MAX_PRINTED = 40;

   // Request payload as packed into req_tdata, segment_slot in the low bits
   typedef struct packed {
      logic [31:0] target_word;
      logic [31:0] reloc_offset;
      logic [7:0]  base_segment;
      logic [7:0]  offset_segment;
      logic [7:0]  reloc_type;
      logic [31:0] segment_base;
      logic [3:0]  segment_slot;
   } reloc_item_t;

   // One patch transaction as seen on the result channel
   typedef struct {
      logic        write_valid;
      logic [31:0] write_address;
      logic [31:0] write_data;
      status_type  status;
      logic        last;
   } patch_t;

   class reloc_patch_scoreboard;
      logic [31:0] seg_base_table [SEGMENT_SLOTS_DEF];
      logic [31:0] hi16_addr_q [$];
      logic [31:0] hi16_word_q [$];
      logic [15:0] held_high_half;
      patch_t      expected_patches [$];
      int          mismatches;
      int          patches_checked;

      function new();
         foreach (seg_base_table[i]) seg_base_table[i] = '0;
         held_high_half  = '0;
         mismatches      = 0;
         patches_checked = 0;
      endfunction

      function int outstanding();
         return expected_patches.size();
      endfunction

      function void push_patch(logic valid, logic [31:0] addr, logic [31:0] data,
                               status_type status, logic last);
         patch_t p;
         p.write_valid   = valid;
         p.write_address = addr;
         p.write_data    = data;
         p.status        = status;
         p.last          = last;
         expected_patches.insert(expected_patches.size(), p);
      endfunction

      // Work out every patch one apply transaction produces
      function void predict_patches(reloc_item_t it);
         logic [31:0] addr, sym, data, r;
         logic [15:0] lo_half;
         // type is judged before the segments
         case (it.reloc_type)
            RT_NONE, RT_R32, RT_R26, RT_HI16, RT_LO16: ;
            RT_GPREL: begin
               push_patch(1'b0, '0, '0, ST_GP, 1'b1);
               return;
            end
            default: begin
               push_patch(1'b0, '0, '0, ST_UNIMP, 1'b1);
               return;
            end
         endcase
         if (it.offset_segment >= SEGMENT_SLOTS_DEF || it.base_segment >= SEGMENT_SLOTS_DEF) begin
            push_patch(1'b0, '0, '0, ST_BADSEG, 1'b1);
            return;
         end
         addr = seg_base_table[it.offset_segment[3:0]] + it.reloc_offset;
         sym  = seg_base_table[it.base_segment[3:0]];
         data = it.target_word;
         case (it.reloc_type)
            RT_R32: data = it.target_word + sym;
            RT_R26: begin
               r    = (((it.target_word & R26_FIELD) << 2) + sym) >> 2;
               data = (it.target_word & ~R26_FIELD) | (r & R26_FIELD);
            end
            RT_HI16: begin
               if (hi16_addr_q.size() >= PENDING_DEPTH_DEF) begin
                  push_patch(1'b0, '0, '0, ST_FULL, 1'b1);
                  return;
               end
               hi16_addr_q.insert(hi16_addr_q.size(), addr);
               hi16_word_q.insert(hi16_word_q.size(), it.target_word);
               held_high_half = it.target_word[15:0];
            end
            RT_LO16: begin
               lo_half = it.target_word[15:0];
               // waiting HI16 words first, with carry correction
               foreach (hi16_word_q[i]) begin
                  r = {hi16_word_q[i][15:0], 16'h0000} + {16'h0000, lo_half} + sym;
                  if (lo_half[15]) r = r - HALF_STEP;
                  if (r[15]) r = r + HALF_STEP;
                  push_patch(1'b1, hi16_addr_q[i], {hi16_word_q[i][31:16], r[31:16]},
                             ST_OK, 1'b0);
               end
               hi16_addr_q.delete();
               hi16_word_q.delete();
               r    = {held_high_half, lo_half} + sym;
               data = {it.target_word[31:16], r[15:0]};
            end
            default: ;
         endcase
         push_patch(1'b1, addr, data, ST_OK, 1'b1);
      endfunction

      // Called for every request transaction accepted by the block
      function void note_request(action_type act, reloc_item_t it);
         case (act)
            ACT_SET: begin
               if (it.segment_slot < SEGMENT_SLOTS_DEF)
                  seg_base_table[it.segment_slot] = it.segment_base;
            end
            ACT_START: begin
               hi16_addr_q.delete();
               hi16_word_q.delete();
               held_high_half = '0;
            end
            ACT_APPLY: predict_patches(it);
            default: ;
         endcase
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         if (mismatches < MAX_PRINTED)
            $display("%0t: patch %0d %s: got 0x%08h, expected 0x%08h",
                     $time, patches_checked, what, got, want);
         mismatches++;
      endtask

      // Compare one result transaction with the oldest expected patch
      task check_response(logic [RSP_TDATA_W-1:0] data, logic valid_bit, logic last_bit);
         patch_t want;
         if (expected_patches.size() == 0) begin
            report_mismatch("result with nothing outstanding", data[31:0], '0);
            return;
         end
         want = expected_patches.pop_front();
         if (valid_bit !== want.write_valid)
            report_mismatch("write_valid", 32'(valid_bit), 32'(want.write_valid));
         if (data[31:0] !== want.write_address)
            report_mismatch("write_address", data[31:0], want.write_address);
         if (data[63:32] !== want.write_data)
            report_mismatch("write_data", data[63:32], want.write_data);
         if (data[66:64] !== want.status)
            report_mismatch("status", 32'(data[66:64]), 32'(want.status));
         if (last_bit !== want.last)
            report_mismatch("last", 32'(last_bit), 32'(want.last));
         patches_checked++;
      endtask
   endclass

endpackage

### bench/tb_mips_relocation_engine_top.sv
// Top-level bench: directed and random relocation streams against a write-patch scoreboard.
`timescale 1ns / 100ps
module tb_mips_relocation_engine_top;
   import mre_pkg::*;
   import tb_reloc_pkg::*;

   localparam int ITEM_TARGET  = 310;
   localparam int PHASE2_AT    = 135;
   localparam int PHASE3_AT    = 235;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 300000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [1:0]             req_tuser  = ACT_NOP;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   reloc_patch_scoreboard sb = new();

   int send_idle_pct    = 26;
   int recv_idle_pct    = 52;
   int items_sent       = 0;
   int cycle_count      = 0;
   bit hold_off_request = 1'b0;

   mips_relocation_engine_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side: check each transaction, random stalls, one long hold-off on request
   initial begin : response_sink
      int held;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Random field values, leaning on the extremes
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_segment();
      if ($urandom_range(9) == 0) return 8'($urandom_range(255));
      return 8'($urandom_range(SEGMENT_SLOTS_DEF - 1));
   endfunction

   function automatic logic [7:0] pick_type();
      case ($urandom_range(11))
         0:       return RT_NONE;
         1, 2:    return RT_R32;
         3, 4:    return RT_R26;
         5:       return RT_HI16;
         6:       return RT_LO16;
         7:       return RT_GPREL;
         8:       return RT_R16;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic reloc_item_t random_item();
      reloc_item_t it;
      it.segment_slot   = 4'($urandom);
      it.segment_base   = $urandom;
      it.reloc_type     = 8'($urandom);
      it.offset_segment = 8'($urandom);
      it.base_segment   = 8'($urandom);
      it.reloc_offset   = $urandom;
      it.target_word    = $urandom;
      return it;
   endfunction

   // Offer one request transaction and wait for its acceptance
   task automatic send_item(action_type act, reloc_item_t it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {4'b0000, it};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(act, it);
      if (act != ACT_NOP) items_sent++;
   endtask

   task automatic set_segment(logic [3:0] slot, logic [31:0] base);
      reloc_item_t it;
      it              = random_item();
      it.segment_slot = slot;
      it.segment_base = base;
      send_item(ACT_SET, it);
   endtask

   task automatic start_section();
      send_item(ACT_START, random_item());
   endtask

   task automatic apply_reloc(logic [7:0] rtype, logic [7:0] oseg, logic [7:0] bseg,
                              logic [31:0] roff, logic [31:0] word);
      reloc_item_t it;
      it                = random_item();
      it.reloc_type     = rtype;
      it.offset_segment = oseg;
      it.base_segment   = bseg;
      it.reloc_offset   = roff;
      it.target_word    = word;
      send_item(ACT_APPLY, it);
   endtask

   // Stop offering and wait until every expected patch has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // A HI16 run closed by LO16, with some stray entries mixed in
   task automatic run_hi_lo_section(int hi_n);
      int i;
      if ($urandom_range(9) < 7) start_section();
      for (i = 0; i < hi_n; i++) begin
         if ($urandom_range(7) == 0)
            apply_reloc(pick_type(), pick_segment(), pick_segment(), $urandom, pick_word());
         apply_reloc(RT_HI16, pick_segment(), pick_segment(), $urandom, pick_word());
      end
      apply_reloc(RT_LO16, pick_segment(), pick_segment(), $urandom, pick_word());
      if ($urandom_range(3) == 0)
         apply_reloc(RT_LO16, pick_segment(), pick_segment(), $urandom, pick_word());
   endtask

   // Stimulus
   initial begin : stimulus
      int  phase;
      int  hi_n;
      bit  first_burst;
      phase       = 1;
      first_burst = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: table extremes, every type, error paths
      set_segment(4'd0, 32'h0000_1000);
      set_segment(4'd15, 32'hFFFF_FFFF);
      set_segment(4'd7, 32'h8000_0000);
      apply_reloc(RT_NONE, 8'd0, 8'd15, 32'hFFFF_FFFF, 32'h0000_0000);
      apply_reloc(RT_R32, 8'd15, 8'd15, 32'h0000_0000, 32'hFFFF_FFFF);
      apply_reloc(RT_R26, 8'd0, 8'd7, 32'h0000_0004, 32'hFFFF_FFFF);
      apply_reloc(RT_R26, 8'd15, 8'd15, 32'h0000_0008, 32'h0000_0000);
      apply_reloc(RT_R16, 8'd0, 8'd0, 32'h0, 32'h1234_5678);
      apply_reloc(8'd3, 8'd0, 8'd0, 32'h0, 32'h1234_5678);
      apply_reloc(8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // GPREL with bad segments: type wins
      apply_reloc(RT_GPREL, 8'd200, 8'd16, 32'h0, 32'h0);
      apply_reloc(RT_R32, 8'd16, 8'd0, 32'h0, 32'h0);
      apply_reloc(RT_NONE, 8'd0, 8'hFF, 32'h0, 32'h0);
      start_section();
      apply_reloc(RT_HI16, 8'd0, 8'd0, 32'h0000_0010, 32'h1234_7FFF);
      apply_reloc(RT_HI16, 8'd15, 8'd7, 32'h0000_0020, 32'hFFFF_FFFF);
      // LO16 with bit 15 of the low half set
      apply_reloc(RT_LO16, 8'd0, 8'd7, 32'h0000_0030, 32'h0000_8000);
      // LO16 with nothing waiting patches only its own low half
      apply_reloc(RT_LO16, 8'd7, 8'd15, 32'h0000_0040, 32'hFFFF_7FFF);
      send_item(ACT_NOP, random_item());
      set_segment(4'd1, 32'h0000_0000);
      apply_reloc(RT_HI16, 8'd1, 8'd1, 32'h0000_0050, 32'hABCD_0001);
      start_section();
      apply_reloc(RT_LO16, 8'd1, 8'd15, 32'h0000_0060, 32'h5555_FFFF);
      apply_reloc(RT_HI16, 8'd1, 8'd1, 32'h0000_0070, 32'h0000_FFFF);
      apply_reloc(RT_LO16, 8'd0, 8'd15, 32'h0000_0080, 32'h0000_FFFF);

      // random part, starting with a long receiver hold-off
      hold_off_request = 1'b1;
      while (items_sent < ITEM_TARGET) begin
         if (phase == 1 && items_sent >= PHASE2_AT) begin
            wait_drained();
            phase         = 2;
            send_idle_pct = 52;
            recv_idle_pct = 26;
         end
         if (phase == 2 && items_sent >= PHASE3_AT) begin
            wait_drained();
            phase            = 3;
            send_idle_pct    = 0;
            recv_idle_pct    = 0;
            hold_off_request = 1'b1;
         end
         case ($urandom_range(9))
            0, 1: repeat ($urandom_range(1, 3)) set_segment(4'($urandom), pick_word());
            2, 3, 4, 5: begin
               // first section overfills the pending list
               if (first_burst) hi_n = PENDING_DEPTH_DEF + 1;
               else if ($urandom_range(7) == 0)
                  hi_n = $urandom_range(PENDING_DEPTH_DEF - 2, PENDING_DEPTH_DEF + 2);
               else hi_n = $urandom_range(0, 4);
               first_burst = 1'b0;
               run_hi_lo_section(hi_n);
            end
            6, 7, 8: apply_reloc(pick_type(), pick_segment(), pick_segment(), $urandom,
                                 pick_word());
            default: begin
               if ($urandom_range(1) == 0) send_item(ACT_NOP, random_item());
               else start_section();
            end
         endcase
      end

      // drain and settle
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mre_pkg.sv
rtl/mre_ram.sv
rtl/mre_alu.sv
rtl/mre_seq.sv
rtl/mips_relocation_engine_top.sv
bench/tb_reloc_pkg.sv
bench/tb_mips_relocation_engine_top.sv
